[rtl/bbp_pkg.sv]
// Shared types, constants and helpers for the boiler band power block.
// Used by the front, queue, back and top-level modules of the block; depends on nothing.
`default_nettype none

package bbp_pkg;

   localparam int QUEUE_DEPTH_DEF = 2;

   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WINDOW_MS,
      CSR_MAX_TEMP
   } csr_addr_type;

   localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;
   localparam logic [11:0] MAX_TEMP_RESET  = 12'd1920;

   localparam logic [12:0] BREW_FULL_BAND    = 13'd80;
   localparam logic [12:0] IDLE_FULL_BAND    = 13'd480;
   localparam logic [12:0] IDLE_HALF_BAND    = 13'd320;
   localparam logic [12:0] IDLE_QUARTER_BAND = 13'd160;
   localparam logic [7:0]  FLOW_ONE          = 8'd16;
   localparam logic [2:0]  DIV_LOW_FLOW      = 3'd7;
   localparam logic [2:0]  DIV_HIGH_FLOW     = 3'd5;

   // Reciprocal of ten, exact for every 16-bit dividend.
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   localparam logic [6:0] PCT_ZERO    = 7'd0;
   localparam logic [6:0] PCT_TENTH   = 7'd10;
   localparam logic [6:0] PCT_QUARTER = 7'd25;
   localparam logic [6:0] PCT_HALF    = 7'd50;
   localparam logic [6:0] PCT_FULL    = 7'd100;

   typedef enum logic [2:0] {
      LVL_ZERO,
      LVL_TENTH,
      LVL_QUARTER,
      LVL_HALF,
      LVL_FULL
   } level_type;

   typedef enum logic [1:0] {
      ELEM_KEEP,
      ELEM_ON,
      ELEM_OFF
   } elem_ctl_type;

   typedef struct packed {
      logic [31:0]  now_ms;
      level_type    level;
      elem_ctl_type elem_ctl;
   } item_type;

   function automatic logic [6:0] level_percent(input level_type lvl);
      logic [6:0] pct;
      unique case (lvl)
         LVL_TENTH:   pct = PCT_TENTH;
         LVL_QUARTER: pct = PCT_QUARTER;
         LVL_HALF:    pct = PCT_HALF;
         LVL_FULL:    pct = PCT_FULL;
         default:     pct = PCT_ZERO;
      endcase
      return pct;
   endfunction

endpackage

`default_nettype wire

[rtl/bbp_front.sv]
// Front part: classifies one control step into a power level and an element action.
// Depends on bbp_pkg.
`default_nettype none

module bbp_front (
   input  wire logic [31:0]       now_ms,
   input  wire logic [11:0]       measured_temp,
   input  wire logic [11:0]       target_temp,
   input  wire logic              brew_active,
   input  wire logic [7:0]        pump_flow,
   input  wire logic [11:0]       max_temp,
   output bbp_pkg::item_type      item
);
   import bbp_pkg::*;

   logic [12:0] t_ext;
   logic [12:0] s_ext;
   logic [2:0]  k;
   logic [14:0] tk;
   logic [14:0] sk;
   logic [19:0] sf;
   logic [21:0] brew_lhs;
   logic [21:0] brew_rhs;

   always_comb begin
      t_ext    = {1'b0, measured_temp};
      s_ext    = {1'b0, target_temp};
      k        = (pump_flow < FLOW_ONE) ? DIV_LOW_FLOW : DIV_HIGH_FLOW;
      tk       = {3'b000, measured_temp} * {12'd0, k};
      sk       = {3'b000, target_temp} * {12'd0, k};
      sf       = {8'd0, target_temp} * {12'd0, pump_flow};
      brew_lhs = {2'b00, tk, 5'b00000};
      brew_rhs = {2'b00, sk, 5'b00000} + {2'b00, sf};

      item.now_ms = now_ms;
      priority if (measured_temp > max_temp) begin
         item.level    = LVL_ZERO;
         item.elem_ctl = ELEM_OFF;
      end else if (brew_active) begin
         priority if (t_ext + BREW_FULL_BAND <= s_ext) begin
            item.level    = LVL_FULL;
            item.elem_ctl = ELEM_ON;
         end else if (brew_lhs <= brew_rhs) begin
            item.level    = LVL_HALF;
            item.elem_ctl = ELEM_KEEP;
         end else begin
            item.level    = LVL_ZERO;
            item.elem_ctl = ELEM_OFF;
         end
      end else begin
         priority if (t_ext + IDLE_FULL_BAND <= s_ext) begin
            item.level    = LVL_FULL;
            item.elem_ctl = ELEM_ON;
         end else if (t_ext + IDLE_HALF_BAND <= s_ext) begin
            item.level    = LVL_HALF;
            item.elem_ctl = ELEM_KEEP;
         end else if (t_ext + IDLE_QUARTER_BAND <= s_ext) begin
            item.level    = LVL_QUARTER;
            item.elem_ctl = ELEM_KEEP;
         end else if (t_ext < s_ext) begin
            item.level    = LVL_TENTH;
            item.elem_ctl = ELEM_KEEP;
         end else begin
            item.level    = LVL_ZERO;
            item.elem_ctl = ELEM_OFF;
         end
      end
   end

endmodule

`default_nettype wire

[rtl/bbp_queue.sv]
// Short first-in first-out queue of classified items between front and back.
// Depends on bbp_pkg.
`default_nettype none

module bbp_queue #(
   parameter int DEPTH = bbp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire bbp_pkg::item_type push_item,
   output logic                   full,
   input  wire logic              pop,
   output logic                   head_valid,
   output bbp_pkg::item_type      head_item
);
   import bbp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   item_type           entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      full       = (count_ff == CNT_W'(DEPTH));
      head_valid = (count_ff != '0);
      head_item  = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in  = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in   = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

[rtl/bbp_back.sv]
// Back part: heater period timing, element drive state and the result register.
// Depends on bbp_pkg.
`default_nettype none

module bbp_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [15:0]       window_ms,
   input  wire logic              head_valid,
   input  wire bbp_pkg::item_type head_item,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [7:0]             rsp_tdata
);
   import bbp_pkg::*;

   logic [15:0] div10_ff;
   logic [31:0] div10_prod;
   logic [31:0] window_start_ff, window_start_in;
   logic        element_on_ff, element_on_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [7:0]  rsp_tdata_ff, rsp_tdata_in;
   logic [15:0] on_time;
   logic [31:0] elapsed;
   logic [31:0] elapsed_new;
   logic        restart;
   logic        elem;

   always_comb begin
      div10_prod = {16'd0, window_ms} * {16'd0, DIV10_MUL};

      unique case (head_item.level)
         LVL_FULL:    on_time = window_ms;
         LVL_HALF:    on_time = {1'b0, window_ms[15:1]};
         LVL_QUARTER: on_time = {2'b00, window_ms[15:2]};
         LVL_TENTH:   on_time = div10_ff;
         default:     on_time = '0;
      endcase

      elapsed = head_item.now_ms - window_start_ff;
      restart = (elapsed >= {16'd0, window_ms}) || (window_start_ff > head_item.now_ms);

      unique case (head_item.elem_ctl)
         ELEM_ON:  elem = 1'b1;
         ELEM_OFF: elem = 1'b0;
         default:  elem = element_on_ff;
      endcase
      if (restart) begin
         elem = 1'b1;
      end
      elapsed_new = restart ? '0 : elapsed;
      if (elapsed_new >= {16'd0, on_time}) begin
         elem = 1'b0;
      end

      pop             = head_valid && (!rsp_tvalid_ff || rsp_tready);
      window_start_in = window_start_ff;
      element_on_in   = element_on_ff;
      rsp_tdata_in    = rsp_tdata_ff;
      rsp_tvalid_in   = rsp_tvalid_ff && !rsp_tready;
      if (pop) begin
         window_start_in = restart ? head_item.now_ms : window_start_ff;
         element_on_in   = elem;
         rsp_tdata_in    = {elem, level_percent(head_item.level)};
         rsp_tvalid_in   = 1'b1;
      end

      rsp_tvalid = rsp_tvalid_ff;
      rsp_tdata  = rsp_tdata_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_start_ff <= '0;
         element_on_ff   <= 1'b0;
         rsp_tvalid_ff   <= 1'b0;
      end else begin
         window_start_ff <= window_start_in;
         element_on_ff   <= element_on_in;
         rsp_tvalid_ff   <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      div10_ff     <= {3'b000, div10_prod[DIV10_SHIFT+12:DIV10_SHIFT]};
      rsp_tdata_ff <= rsp_tdata_in;
   end

endmodule

`default_nettype wire

[rtl/boiler_band_power_with_pwm_window.sv]
// Top level of the stepped, time-proportioned boiler heater control.
// Depends on bbp_pkg, bbp_front, bbp_queue and bbp_back.
`default_nettype none

// The block takes one control step per clock cycle while its queue is not full and returns one
// result per step, through a queue entry and then the result register. The back part sets the
// rate: it updates the period start and element drive once per item, when its result register
// is free; the queue of QUEUE_DEPTH items lets the input side keep going while a result waits.
// The tenth-of-period on time follows a new window_ms value in the cycle after the other on times.
module boiler_band_power_with_pwm_window #(
   parameter int QUEUE_DEPTH = bbp_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // now_ms[31:0], measured_temp[43:32], target_temp[55:44], pump_flow[63:56]
   input  wire logic [63:0]                     req_tdata,
   // brew_active[0]
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // power_percent[6:0], heater_on[7]
   output logic [7:0]                           rsp_tdata,
   input  wire logic                            csr_we,
   input  wire logic [bbp_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [bbp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import bbp_pkg::*;

   logic [15:0] window_ms_ff, window_ms_in;
   logic [11:0] max_temp_ff, max_temp_in;
   item_type    front_item;
   item_type    head_item;
   logic        queue_full;
   logic        head_valid;
   logic        pop;
   logic        push;

   always_comb begin
      window_ms_in = window_ms_ff;
      max_temp_in  = max_temp_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_WINDOW_MS: window_ms_in = csr_wdata;
            CSR_MAX_TEMP:  max_temp_in  = csr_wdata[11:0];
            default:       window_ms_in = window_ms_ff;
         endcase
      end
      req_tready = !queue_full;
      push       = req_tvalid && !queue_full;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= WINDOW_MS_RESET;
         max_temp_ff  <= MAX_TEMP_RESET;
      end else begin
         window_ms_ff <= window_ms_in;
         max_temp_ff  <= max_temp_in;
      end
   end

   bbp_front u_front (
      .now_ms        (req_tdata[31:0]),
      .measured_temp (req_tdata[43:32]),
      .target_temp   (req_tdata[55:44]),
      .brew_active   (req_tuser),
      .pump_flow     (req_tdata[63:56]),
      .max_temp      (max_temp_ff),
      .item          (front_item)
   );

   bbp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (front_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   bbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .window_ms  (window_ms_ff),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

[rtl/bbp_checker.sv]
// Port-level checks of the boiler band power block, bound to its top level.
// Depends only on the top level's clock, reset and result ports.
`default_nettype none

module bbp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_tvalid,
   input wire logic       rsp_tready,
   input wire logic [7:0] rsp_tdata
);

   // A stalled result item holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // Only the five defined power levels appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] == 7'd0 || rsp_tdata[6:0] == 7'd10 ||
                      rsp_tdata[6:0] == 7'd25 || rsp_tdata[6:0] == 7'd50 ||
                      rsp_tdata[6:0] == 7'd100))
      else $error("undefined power level");

   // A zero level always leaves the element off.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[6:0] == 7'd0) |-> !rsp_tdata[7])
      else $error("element on at zero power");

   // No result item right after reset.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind boiler_band_power_with_pwm_window bbp_checker u_bbp_checker (.*);

`default_nettype wire

[tb/boiler_band_power_with_pwm_window_tb.sv]
// Testbench for the stepped boiler heater control: directed band, cutoff, timestamp and
// period cases, then random control steps under several register settings.
// Depends on bbp_pkg and boiler_band_power_with_pwm_window.
`timescale 1ns / 1ps

module boiler_band_power_with_pwm_window_tb;
   import bbp_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct packed {
      logic       heater_on;
      logic [6:0] power_pct;
   } heater_cmd_type;

   typedef enum int {READY_ALWAYS, READY_LIGHT, READY_HEAVY} ready_mode_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [63:0]           req_tdata  = '0;
   logic                  req_tuser  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;
   logic                  csr_we     = 1'b0;
   csr_addr_type          csr_addr   = CSR_WINDOW_MS;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   logic [15:0] window_cfg     = WINDOW_MS_RESET;
   logic [11:0] temp_limit_cfg = MAX_TEMP_RESET;
   logic [31:0] period_start   = '0;
   logic        element_on     = 1'b0;

   heater_cmd_type expected_cmds[$];
   int          mismatches, items_sent, results_checked, heater_on_seen, csr_writes;
   int          idle_cycles, burst_left, gap_max, burst_max, stall_left, mode_left;
   ready_mode_type ready_mode;
   logic [31:0] clk_ms = '0;

   boiler_band_power_with_pwm_window dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic heater_cmd_type heater_control(input logic [31:0] now,
         input logic [11:0] temp, input logic [11:0] setp, input logic brew,
         input logic [7:0] flow);
      int          t, s, f, k;
      logic [6:0]  pct;
      logic [31:0] on_ms;
      heater_cmd_type cmd;
      t = temp;
      s = setp;
      f = flow;
      if (brew) begin
         if (t <= s - int'(BREW_FULL_BAND)) begin
            pct = PCT_FULL;
            element_on = 1'b1;
         end else begin
            k = (flow < FLOW_ONE) ? int'(DIV_LOW_FLOW) : int'(DIV_HIGH_FLOW);
            if (32 * k * t <= 32 * k * s + s * f) begin
               pct = PCT_HALF;
            end else begin
               pct = PCT_ZERO;
               element_on = 1'b0;
            end
         end
      end else if (t <= s - int'(IDLE_FULL_BAND)) begin
         pct = PCT_FULL;
         element_on = 1'b1;
      end else if (t <= s - int'(IDLE_HALF_BAND)) begin
         pct = PCT_HALF;
      end else if (t <= s - int'(IDLE_QUARTER_BAND)) begin
         pct = PCT_QUARTER;
      end else if (t < s) begin
         pct = PCT_TENTH;
      end else begin
         pct = PCT_ZERO;
         element_on = 1'b0;
      end
      if (temp > temp_limit_cfg) begin
         pct = PCT_ZERO;
         element_on = 1'b0;
      end
      on_ms = (32'(pct) * 32'(window_cfg)) / 32'd100;
      if (now - period_start >= 32'(window_cfg) || period_start > now) begin
         element_on = 1'b1;
         period_start = now;
      end
      if (now - period_start >= on_ms)
         element_on = 1'b0;
      cmd.power_pct = pct;
      cmd.heater_on = element_on;
      return cmd;
   endfunction

   task automatic send_sample(input logic [31:0] now, input logic [11:0] temp,
         input logic [11:0] setp, input logic brew, input logic [7:0] flow);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(burst_max, 1);
         gap = $urandom_range(gap_max, 0);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {flow, setp, temp, now};
      req_tuser <= brew;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      expected_cmds.push_back(heater_control(now, temp, setp, brew, flow));
      items_sent++;
   endtask

   task automatic send_next(input logic [11:0] temp, input logic [11:0] setp,
         input logic brew, input logic [7:0] flow);
      clk_ms += 32'd50;
      send_sample(clk_ms, temp, setp, brew, flow);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
   endtask

   task automatic drain_results();
      release_req();
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input csr_addr_type addr, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (addr == CSR_WINDOW_MS)
         window_cfg = value;
      else
         temp_limit_cfg = value[11:0];
      csr_writes++;
   endtask

   task automatic set_registers(input logic [15:0] window, input logic [11:0] limit);
      drain_results();
      write_csr(CSR_WINDOW_MS, window);
      write_csr(CSR_MAX_TEMP, 16'(limit));
      repeat (3) @(negedge clock);
   endtask

   task automatic send_random_sample();
      int          pick, temp_i, w;
      logic [11:0] setp;
      logic        brew;
      logic [7:0]  flow;
      w = window_cfg;
      pick = $urandom_range(99, 0);
      if (pick < 80)
         clk_ms += $urandom_range((w > 8) ? w / 8 : 1, 0);
      else if (pick < 88)
         clk_ms += $urandom_range(2 * w + 1, w / 2);
      else if (pick < 94)
         clk_ms -= $urandom_range(w + 1, 1);
      else
         clk_ms = $urandom();
      brew = ($urandom_range(9, 0) < 4);
      if ($urandom_range(9, 0) < 7)
         setp = 12'($urandom_range(2200, 400));
      else
         setp = 12'($urandom_range(4095, 0));
      if ($urandom_range(9, 0) < 7) begin
         if (brew)
            temp_i = int'(setp) + int'($urandom_range(520, 0)) - 120;
         else
            temp_i = int'(setp) + int'($urandom_range(640, 0)) - 560;
         if (temp_i < 0)
            temp_i = 0;
         if (temp_i > 4095)
            temp_i = 4095;
      end else begin
         temp_i = $urandom_range(4095, 0);
      end
      if ($urandom_range(1, 0) == 0)
         flow = 8'($urandom_range(24, 8));
      else
         flow = 8'($urandom_range(255, 0));
      send_sample(clk_ms, 12'(temp_i), setp, brew, flow);
   endtask

   task automatic test_idle_bands();
      gap_max = 2;
      burst_max = 4;
      send_next(12'd520, 12'd1000, 1'b0, 8'd0);
      send_next(12'd521, 12'd1000, 1'b0, 8'hFF);
      send_next(12'd680, 12'd1000, 1'b0, 8'd0);
      send_next(12'd840, 12'd1000, 1'b0, 8'd0);
      send_next(12'd841, 12'd1000, 1'b0, 8'd0);
      send_next(12'd999, 12'd1000, 1'b0, 8'd0);
      send_next(12'd1000, 12'd1000, 1'b0, 8'd0);
   endtask

   task automatic test_brew_bands();
      send_next(12'd920, 12'd1000, 1'b1, 8'd16);
      send_next(12'd921, 12'd1000, 1'b1, 8'd16);
      send_next(12'd1100, 12'd1000, 1'b1, 8'd16);
      send_next(12'd1101, 12'd1000, 1'b1, 8'd16);
      send_next(12'd1066, 12'd1000, 1'b1, 8'd15);
      send_next(12'd1067, 12'd1000, 1'b1, 8'd15);
      send_next(12'd1000, 12'd1000, 1'b1, 8'd0);
      send_next(12'd1001, 12'd1000, 1'b1, 8'd0);
   endtask

   task automatic test_overtemp_cutoff();
      send_next(12'd1920, 12'd4095, 1'b0, 8'hFF);
      send_next(12'd1921, 12'd4095, 1'b0, 8'hFF);
      set_registers(16'd1000, 12'd0);
      send_next(12'd0, 12'd4095, 1'b0, 8'd0);
      send_next(12'd1, 12'd4095, 1'b0, 8'd0);
      set_registers(16'd1000, 12'd4095);
      send_next(12'd4095, 12'd4095, 1'b1, 8'd255);
      set_registers(WINDOW_MS_RESET, MAX_TEMP_RESET);
   endtask

   task automatic test_timestamp_restart();
      clk_ms = 32'hFFFF_FFF0;
      send_sample(clk_ms, 12'd0, 12'd0, 1'b0, 8'hFF);
      clk_ms = 32'd5;
      send_sample(clk_ms, 12'd0, 12'd4095, 1'b0, 8'd0);
   endtask

   task automatic test_window_extremes();
      set_registers(16'd1, MAX_TEMP_RESET);
      send_next(12'd0, 12'd4095, 1'b0, 8'd0);
      set_registers(16'd0, MAX_TEMP_RESET);
      send_next(12'd0, 12'd4095, 1'b0, 8'd0);
      send_next(12'd1000, 12'd1000, 1'b0, 8'd0);
      set_registers(16'hFFFF, 12'd4095);
      send_next(12'd0, 12'd4095, 1'b0, 8'd0);
   endtask

   task automatic run_phase(input logic [15:0] window, input logic [11:0] limit,
         input int count, input int gaps, input int burst);
      set_registers(window, limit);
      gap_max = gaps;
      burst_max = burst;
      for (int i = 0; i < count; i++) begin
         if (i == count / 2 || $urandom_range(199, 0) == 0)
            drain_results();
         send_random_sample();
      end
   endtask

   task automatic test_random_traffic();
      run_phase(WINDOW_MS_RESET, MAX_TEMP_RESET, 400, 4, 8);
      run_phase(16'd1, 12'd4095, 150, 0, 1);
      run_phase(16'hFFFF, MAX_TEMP_RESET, 200, 10, 3);
      run_phase(16'($urandom_range(5000, 2)), 12'($urandom_range(4095, 0)), 200, 2, 16);
      run_phase(16'd250, 12'd0, 50, 3, 5);
      run_phase(16'($urandom_range(65535, 1)), 12'($urandom_range(4095, 1000)), 350, 6, 6);
   endtask

   always @(negedge clock) begin
      if (mode_left == 0) begin
         mode_left = $urandom_range(300, 50);
         ready_mode = ready_mode_type'($urandom_range(2, 0));
      end else begin
         mode_left--;
      end
      if (stall_left != 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (ready_mode == READY_LIGHT && $urandom_range(3, 0) == 0) begin
         stall_left = $urandom_range(2, 0);
         rsp_tready <= 1'b0;
      end else if (ready_mode == READY_HEAVY && $urandom_range(1, 0) == 0) begin
         stall_left = $urandom_range(20, 0);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      heater_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (expected_cmds.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: power %0d heater %0b", rsp_tdata[6:0],
                        rsp_tdata[7]);
         end else begin
            want = expected_cmds.pop_front();
            if (want.heater_on)
               heater_on_seen++;
            if (rsp_tdata[6:0] !== want.power_pct || rsp_tdata[7] !== want.heater_on) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Mismatch on result %0d: expected power %0d heater %0b, ",
                            "got power %0d heater %0b"},
                           results_checked, want.power_pct, want.heater_on, rsp_tdata[6:0],
                           rsp_tdata[7]);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles = 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles, %0d results outstanding.",
                  IDLE_LIMIT, expected_cmds.size());
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles++;
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_idle_bands();
      test_brew_bands();
      test_overtemp_cutoff();
      test_timestamp_restart();
      test_window_extremes();
      test_random_traffic();
      release_req();
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Covered %0d control steps across %0d register writes; %0d results checked.",
               items_sent, csr_writes, results_checked);
      $display("Heater was on in %0d results; %0d mismatches seen.", heater_on_seen,
               mismatches);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
rtl/bbp_pkg.sv
rtl/bbp_front.sv
rtl/bbp_queue.sv
rtl/bbp_back.sv
rtl/boiler_band_power_with_pwm_window.sv
rtl/bbp_checker.sv
tb/boiler_band_power_with_pwm_window_tb.sv
